// File: rtl/core/bbw_pkg.sv
// Shared constants and types for the box blur window filter.
`default_nettype none
package bbw_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_KERNEL_DEF = 7;
    localparam int PIX_W          = 8;
    localparam int FW_W           = 11;
    localparam int FH_W           = 16;
    localparam int KS_W           = 3;
    localparam int CFG_W          = 16;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KERNEL_SIZE  = 2'd2;

    localparam logic OP_PIXEL = 1'b0;

    typedef struct packed {
        logic clear;
        logic acc;
        logic start;
        logic step;
    } lane_ctl_t;
endpackage
`default_nettype wire

// File: rtl/core/bbw_line_store.sv
// Ring of image rows: one write port, one registered read port.
`default_nettype none
module bbw_line_store #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [23:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [23:0]   rd_data
);
    logic [23:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/bbw_lane.sv
// One color lane: window accumulator and rounded restoring divider.
`default_nettype none
module bbw_lane #(
    parameter int SUM_W = 14,
    parameter int CNT_W = 6,
    parameter int NUM_W = 14
) (
    input  wire logic                      clk,
    input  wire bbw_pkg::lane_ctl_t        ctl,
    input  wire logic [bbw_pkg::PIX_W-1:0] pix,
    input  wire logic [CNT_W-1:0]          count,
    output logic      [bbw_pkg::PIX_W-1:0] mean
);
    logic [SUM_W-1:0] sum_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, count};
    assign mean   = quo_reg[bbw_pkg::PIX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            sum_reg <= '0;
        end
        else if (ctl.acc)
        begin
            sum_reg <= sum_reg + SUM_W'(pix);
        end
        if (ctl.start)
        begin
            num_reg <= NUM_W'(sum_reg) + NUM_W'(count >> 1);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (ctl.step)
        begin
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? CNT_W'(rem_sh - {1'b0, count}) : CNT_W'(rem_sh);
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/box_blur_window_filter.sv
// Top level: box blur window filter with control sequencer and RGB lanes.
`default_nettype none
// Takes one beat at a time: s_axis_tready is high only while the sequencer is idle.
// A pixel or flush beat with no output due only goes through accept and the position check.
// A beat that makes an output goes through accept and check, one line-store read
// per in-bounds window pixel (N*N inside the frame, fewer at the border), the setup
// states S_LAST and S_START, the divider steps and the load of the output register;
// it waits longer in S_OUT while the previous output beat is held.
// Border pixels average only in-bounds neighbors, rounded half up.
module box_blur_window_filter #(
    parameter int MAX_WIDTH  = bbw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = bbw_pkg::MAX_KERNEL_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [23:0]                s_axis_tdata,  // red_in, green_in, blue_in
    input  wire logic                       s_axis_tuser,  // operation
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic      [23:0]                m_axis_tdata,  // red_out, green_out, blue_out
    output logic                            m_axis_tlast,  // frame_end
    input  wire logic                       cfg_wr_en,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [bbw_pkg::CFG_W-1:0]  cfg_data
);
    localparam int RING   = MAX_KERNEL + 1;
    localparam int SLOT_W = $clog2(RING);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int DEPTH  = RING * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int KK     = MAX_KERNEL * MAX_KERNEL;
    localparam int CNT_W  = $clog2(KK + 1);
    localparam int SUM_W  = $clog2(255 * KK + 1);
    localparam int NUM_W  = $clog2(255 * KK + KK / 2 + 1);
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam int RW     = bbw_pkg::FH_W;
    localparam int CX     = COL_W + 5;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SUM, S_LAST, S_START, S_DIV, S_OUT} state_t;

    state_t                     state_reg;
    logic [bbw_pkg::FW_W-1:0]   fw_reg;
    logic [bbw_pkg::FH_W-1:0]   fh_reg;
    logic [bbw_pkg::KS_W-1:0]   ks_reg;
    logic [COL_W-1:0]           in_col_reg;
    logic [RW-1:0]              in_row_reg;
    logic [SLOT_W-1:0]          in_slot_reg;
    logic [COL_W-1:0]           out_col_reg;
    logic [RW-1:0]              out_row_reg;
    logic [SLOT_W-1:0]          out_slot_reg;
    logic [COL_W-1:0]           rd_col_reg;
    logic [RW-1:0]              rd_row_reg;
    logic [SLOT_W-1:0]          rd_slot_reg;
    logic [COL_W-1:0]           c0_reg;
    logic [COL_W-1:0]           nc_reg;
    logic [RW-1:0]              nr_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       rd_pend_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       out_valid_reg;
    logic [23:0]                out_data_reg;
    logic                       out_last_reg;

    logic [WW-1:0]              eff_w;
    logic [RW-1:0]              eff_h;
    logic [3:0]                 k_cap;
    logic [3:0]                 k_odd;
    logic [2:0]                 h;
    logic [RW:0]                r_plus;
    logic [CX-1:0]              c_plus;
    logic [RW-1:0]              need_r;
    logic [COL_W-1:0]           need_c;
    logic [RW-1:0]              r0;
    logic [COL_W-1:0]           c0;
    logic [SLOT_W-1:0]          rdiff;
    logic [SLOT_W-1:0]          r0_slot;
    logic                       due;
    logic                       is_last;
    logic                       in_accept;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic [23:0]                rd_data;
    bbw_pkg::lane_ctl_t         ctl;
    logic [7:0]                 mean_r;
    logic [7:0]                 mean_g;
    logic [7:0]                 mean_b;
    logic                       out_free;

    always_comb
    begin
        if (fw_reg == '0)
            eff_w = WW'(1);
        else if (32'(fw_reg) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(fw_reg);
        eff_h = (fh_reg == '0) ? RW'(1) : fh_reg;
        k_cap = (32'(ks_reg) > 32'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : 4'(ks_reg);
        k_odd = (k_cap == 4'd0) ? 4'd1 : ((k_cap - 4'd1) | 4'd1);
        h     = k_odd[3:1];
        r_plus = {1'b0, out_row_reg} + (RW + 1)'(h);
        c_plus = CX'(out_col_reg) + CX'(h);
        need_r = (r_plus < (RW + 1)'(eff_h - RW'(1))) ? r_plus[RW-1:0] : eff_h - RW'(1);
        need_c = (c_plus < CX'(eff_w - WW'(1))) ? c_plus[COL_W-1:0] : COL_W'(eff_w - WW'(1));
        r0    = (out_row_reg >= RW'(h)) ? out_row_reg - RW'(h) : '0;
        c0    = (out_col_reg >= COL_W'(h)) ? out_col_reg - COL_W'(h) : '0;
        rdiff = SLOT_W'(out_row_reg - r0);
        r0_slot = (out_slot_reg >= rdiff) ? out_slot_reg - rdiff
                                          : SLOT_W'(out_slot_reg + SLOT_W'(RING) - rdiff);
        due = (in_row_reg > need_r) || (in_row_reg == need_r && in_col_reg > need_c);
        is_last = (out_row_reg == eff_h - RW'(1)) &&
                  (WW'(out_col_reg) == eff_w - WW'(1));
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign wr_en   = in_accept && (s_axis_tuser == bbw_pkg::OP_PIXEL) && (in_row_reg < eff_h);
    assign wr_addr = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    assign rd_addr = AW'(rd_slot_reg) * AW'(MAX_WIDTH) + AW'(rd_col_reg);
    assign out_free = !out_valid_reg || m_axis_tready;

    assign ctl.clear = (state_reg == S_CHECK);
    assign ctl.acc   = rd_pend_reg;
    assign ctl.start = (state_reg == S_START);
    assign ctl.step  = (state_reg == S_DIV) && (step_reg != '0);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    bbw_line_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (state_reg == S_SUM),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bbw_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W), .NUM_W(NUM_W)) u_lane_r (
        .clk(clk), .ctl(ctl), .pix(rd_data[7:0]), .count(cnt_reg), .mean(mean_r)
    );
    bbw_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W), .NUM_W(NUM_W)) u_lane_g (
        .clk(clk), .ctl(ctl), .pix(rd_data[15:8]), .count(cnt_reg), .mean(mean_g)
    );
    bbw_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W), .NUM_W(NUM_W)) u_lane_b (
        .clk(clk), .ctl(ctl), .pix(rd_data[23:16]), .count(cnt_reg), .mean(mean_b)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHECK)
        begin
            c0_reg <= c0;
            nc_reg <= need_c;
            nr_reg <= need_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fw_reg        <= bbw_pkg::FW_W'(640);
            fh_reg        <= bbw_pkg::FH_W'(480);
            ks_reg        <= bbw_pkg::KS_W'(3);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            rd_col_reg    <= '0;
            rd_row_reg    <= '0;
            rd_slot_reg   <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= (state_reg == S_SUM);
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (wr_en)
                    begin
                        if (WW'(in_col_reg) == eff_w - WW'(1))
                        begin
                            in_col_reg  <= '0;
                            in_row_reg  <= in_row_reg + RW'(1);
                            in_slot_reg <= (in_slot_reg == SLOT_W'(RING - 1)) ? '0
                                           : in_slot_reg + SLOT_W'(1);
                        end
                        else
                        begin
                            in_col_reg <= in_col_reg + COL_W'(1);
                        end
                    end
                    if (in_accept)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    rd_row_reg  <= r0;
                    rd_col_reg  <= c0;
                    rd_slot_reg <= r0_slot;
                    cnt_reg     <= '0;
                    state_reg   <= due ? S_SUM : S_IDLE;
                end
                S_SUM:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (rd_col_reg == nc_reg)
                    begin
                        rd_col_reg <= c0_reg;
                        if (rd_row_reg == nr_reg)
                        begin
                            state_reg <= S_LAST;
                        end
                        else
                        begin
                            rd_row_reg  <= rd_row_reg + RW'(1);
                            rd_slot_reg <= (rd_slot_reg == SLOT_W'(RING - 1)) ? '0
                                           : rd_slot_reg + SLOT_W'(1);
                        end
                    end
                    else
                    begin
                        rd_col_reg <= rd_col_reg + COL_W'(1);
                    end
                end
                S_LAST:
                begin
                    state_reg <= S_START;
                end
                S_START:
                begin
                    step_reg  <= STEP_W'(NUM_W);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (step_reg != '0)
                    begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {mean_b, mean_g, mean_r};
                        out_last_reg  <= is_last;
                        state_reg     <= S_IDLE;
                        if (is_last)
                        begin
                            in_col_reg   <= '0;
                            in_row_reg   <= '0;
                            in_slot_reg  <= '0;
                            out_col_reg  <= '0;
                            out_row_reg  <= '0;
                            out_slot_reg <= '0;
                        end
                        else if (WW'(out_col_reg) == eff_w - WW'(1))
                        begin
                            out_col_reg  <= '0;
                            out_row_reg  <= out_row_reg + RW'(1);
                            out_slot_reg <= (out_slot_reg == SLOT_W'(RING - 1)) ? '0
                                            : out_slot_reg + SLOT_W'(1);
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + COL_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_wr_en && (cfg_index == bbw_pkg::REG_FRAME_WIDTH ||
                              cfg_index == bbw_pkg::REG_FRAME_HEIGHT ||
                              cfg_index == bbw_pkg::REG_KERNEL_SIZE))
            begin
                case (cfg_index)
                    bbw_pkg::REG_FRAME_WIDTH:  fw_reg <= cfg_data[bbw_pkg::FW_W-1:0];
                    bbw_pkg::REG_FRAME_HEIGHT: fh_reg <= cfg_data[bbw_pkg::FH_W-1:0];
                    bbw_pkg::REG_KERNEL_SIZE:  ks_reg <= cfg_data[bbw_pkg::KS_W-1:0];
                    default:                   ks_reg <= ks_reg;
                endcase
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_slot_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_slot_reg <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking stream testbench for the box blur window filter.
`timescale 1ns / 1ps
module tb;
    localparam int RING = bbw_pkg::MAX_KERNEL_DEF + 1;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pix_beat_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } blur_px_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [bbw_pkg::CFG_W-1:0] cfg_data = '0;

    box_blur_window_filter i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [10:0] fw_q;
    logic [15:0] fh_q;
    logic [2:0]  ks_q;
    logic [23:0] lines_q [RING*1024];
    int unsigned col_q, row_q, opos_q;

    pix_beat_t beat_q[$];
    blur_px_t  blur_q[$];
    int errors = 0;
    int send_idle = 0, recv_idle = 0;
    int hold_cycles = 0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;

    function automatic void blur_config(input logic [1:0] idx, input logic [15:0] v);
        case (idx)
            bbw_pkg::REG_FRAME_WIDTH:  fw_q = v[10:0];
            bbw_pkg::REG_FRAME_HEIGHT: fh_q = v;
            bbw_pkg::REG_KERNEL_SIZE:  ks_q = v[2:0];
            default: return;
        endcase
        col_q = 0; row_q = 0; opos_q = 0;
    endfunction

    task automatic blur_predict(input pix_beat_t bt);
        int unsigned w, hg, h, k, tot, r, c, nr, nc, cnt;
        int unsigned sr, sg, sb;
        logic [23:0] px;
        blur_px_t o;
        w = (fw_q < 1) ? 1 : (fw_q > 1024 ? 1024 : fw_q);
        hg = (fh_q < 1) ? 1 : fh_q;
        k = ks_q > 7 ? 7 : ks_q;
        k = (k == 0) ? 1 : ((k - 1) | 1);
        h = k / 2;
        tot = w * hg;
        if (bt.op == bbw_pkg::OP_PIXEL && row_q < hg)
        begin
            lines_q[(row_q % RING) * 1024 + col_q] = {bt.r, bt.g, bt.b};
            col_q++;
            if (col_q >= w)
            begin
                col_q = 0;
                row_q++;
            end
        end
        if (opos_q >= tot)
        begin
            col_q = 0; row_q = 0; opos_q = 0;
            return;
        end
        r = opos_q / w;
        c = opos_q % w;
        nr = (r + h < hg - 1) ? r + h : hg - 1;
        nc = (c + h < w - 1) ? c + h : w - 1;
        if (!(row_q > nr || (row_q == nr && col_q > nc))) return;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int unsigned rr = (r >= h ? r - h : 0); rr <= nr; rr++)
            for (int unsigned cc = (c >= h ? c - h : 0); cc <= nc; cc++)
            begin
                px = lines_q[(rr % RING) * 1024 + cc];
                sr += px[23:16]; sg += px[15:8]; sb += px[7:0]; cnt++;
            end
        o.r = 8'((sr + cnt / 2) / cnt);
        o.g = 8'((sg + cnt / 2) / cnt);
        o.b = 8'((sb + cnt / 2) / cnt);
        if (opos_q == tot - 1)
        begin
            o.last = 1'b1;
            col_q = 0; row_q = 0; opos_q = 0;
        end
        else
        begin
            o.last = 1'b0;
            opos_q++;
        end
        blur_q.push_back(o);
    endtask

    initial forever #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready) blur_predict(beat_q.pop_front());
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (beat_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= beat_q[0].op;
                    s_axis_tdata  <= {beat_q[0].b, beat_q[0].g, beat_q[0].r};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver stall counter
    always @(posedge clk)
    begin
        if (hold_req && !hold_seen)
        begin
            hold_seen   <= 1'b1;
            hold_cycles <= 600;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        blur_px_t exp_px;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (blur_q.size() == 0)
                begin
                    $error("unexpected output beat %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    exp_px = blur_q.pop_front();
                    if (m_axis_tdata[7:0] !== exp_px.r)
                    begin
                        $error("red_out exp %0d got %0d", exp_px.r, m_axis_tdata[7:0]);
                        errors++;
                    end
                    if (m_axis_tdata[15:8] !== exp_px.g)
                    begin
                        $error("green_out exp %0d got %0d", exp_px.g, m_axis_tdata[15:8]);
                        errors++;
                    end
                    if (m_axis_tdata[23:16] !== exp_px.b)
                    begin
                        $error("blue_out exp %0d got %0d", exp_px.b, m_axis_tdata[23:16]);
                        errors++;
                    end
                    if (m_axis_tlast !== exp_px.last)
                    begin
                        $error("frame_end exp %0d got %0d", exp_px.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic pix_beat_t rand_beat(input int flush_pct);
        pix_beat_t bt;
        bt.op = ($urandom_range(99) < flush_pct) ? OP_FLUSH : bbw_pkg::OP_PIXEL;
        bt.r = 8'($urandom); bt.g = 8'($urandom); bt.b = 8'($urandom);
        return bt;
    endfunction

    task automatic wait_drain();
        while (beat_q.size() != 0 || s_axis_tvalid || blur_q.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int v);
        @(posedge clk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_data <= v[15:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        blur_config(idx, v[15:0]);
    endtask

    // one frame plus enough flushes to drain it, with some noise mixed in
    task automatic push_frame(input int w, input int hg);
        for (int i = 0; i < w * hg; i++) beat_q.push_back(rand_beat(8));
        for (int i = 0; i < w * 4 + 10; i++) beat_q.push_back(rand_beat(85));
    endtask

    task automatic set_frame(input int w, input int hg, input int k);
        write_reg(bbw_pkg::REG_FRAME_WIDTH, w);
        write_reg(bbw_pkg::REG_FRAME_HEIGHT, hg);
        write_reg(bbw_pkg::REG_KERNEL_SIZE, k);
    endtask

    initial
    begin
        pix_beat_t bt;
        blur_config(bbw_pkg::REG_FRAME_WIDTH, 16'd640);
        blur_config(bbw_pkg::REG_FRAME_HEIGHT, 16'd480);
        blur_config(bbw_pkg::REG_KERNEL_SIZE, 16'd3);
        for (int i = 0; i < RING * 1024; i++) lines_q[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // directed: extremes, flush with nothing pending, index beyond registers
        write_reg(2'd3, 16'hFFFF);
        set_frame(3, 3, 7);
        beat_q.push_back('{op: OP_FLUSH, r: 8'h00, g: 8'h00, b: 8'h00});
        for (int i = 0; i < 9; i++)
        begin
            bt.op = bbw_pkg::OP_PIXEL;
            bt.r = (i % 2) ? 8'hFF : 8'h00; bt.g = 8'hFF - bt.r; bt.b = (i == 4) ? 8'hFF : 8'h01;
            beat_q.push_back(bt);
        end
        for (int i = 0; i < 10; i++) beat_q.push_back(rand_beat(40));
        wait_drain();
        set_frame(1, 1, 0);
        for (int i = 0; i < 4; i++) beat_q.push_back(rand_beat(30));
        wait_drain();
        set_frame(4, 2, 4);
        push_frame(4, 2);
        wait_drain();
        // wide row
        set_frame(1024, 1, 1);
        for (int i = 0; i < 30; i++) beat_q.push_back(rand_beat(0));
        wait_drain();
        write_reg(bbw_pkg::REG_FRAME_WIDTH, 2047);
        write_reg(bbw_pkg::REG_FRAME_WIDTH, 0);
        write_reg(bbw_pkg::REG_FRAME_HEIGHT, 0);
        beat_q.push_back(rand_beat(0));
        wait_drain();
        // random phases
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 82 : 33) : 0;
            recv_idle = (ph == 2 || ph == 3) ? (ph == 2 ? 82 : 33) : 0;
            for (int f = 0; f < 3; f++)
            begin
                int w, hg;
                w = $urandom_range(1, 8);
                hg = $urandom_range(1, 6);
                set_frame(w, hg, $urandom_range(0, 7));
                if (ph == 0 && f == 0) hold_req = 1'b1;
                push_frame(w, hg);
                wait_drain();
            end
        end
        send_idle = 0; recv_idle = 0;
        set_frame(5, 65535, 7);
        for (int i = 0; i < 60; i++) beat_q.push_back(rand_beat(10));
        wait_drain();
        if (errors == 0 && blur_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
